>>> rtl/tcow_pkg.sv
// Shared types, constants and helper functions of the text console output writer.
package tcow_pkg;

    localparam int COLS      = 80;
    localparam int ROWS      = 24;
    localparam int TAB_STOP  = 8;
    localparam int TERMINALS = 8;

    localparam int CELLS = COLS * ROWS;
    localparam int SLOTS = TERMINALS * ROWS;
    localparam int DEPTH = SLOTS * COLS;

    localparam int MODE_W = 2;
    localparam int TERM_W = 3;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;

    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TIDX_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NCOL_W = $clog2(COLS + 2 * TAB_STOP + 1);

    localparam int TAB_S = COL_W;
    localparam int TAB_M = (2 ** TAB_S) / TAB_STOP;
    localparam int IDX_S = IDX_W;
    localparam int IDX_M = (2 ** IDX_S) / COLS;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_TEXT_ATTR = 1'b0;
    localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TERM_W-1:0] terminal;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attribute;
        logic [IDX_W-1:0]  cursor_position;
        logic              scrolled;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_SPACE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NONE,
        OP_BAD_TERM
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TERM_W-1:0] terminal;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SLOT,
        BK_SWEEP,
        BK_WRITE,
        BK_TAB_Q,
        BK_TAB_ADV,
        BK_WRAP,
        BK_CLEAR,
        BK_RD_Q,
        BK_RD_ADJ,
        BK_RD_SLOT,
        BK_RD_MEM,
        BK_RD_DATA,
        BK_DONE
    } t_back_state;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, r} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [TIDX_W-1:0] t,
                                                 input logic [ROW_W-1:0] p);
        return SLOT_W'(t * ROWS) + SLOT_W'(p);
    endfunction

endpackage

>>> rtl/tcow_front.sv
// Front part: accepts input words, classifies them and queues the commands.
module tcow_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tcow_pkg::t_in_word i_in_word,
    output logic           o_cmd_valid,
    output tcow_pkg::t_cmd o_cmd,
    input  logic           i_cmd_take
);
    import tcow_pkg::*;

    t_cmd            r_queue [QDEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_count;
    t_cmd            cls;
    logic            do_push;

    always_comb begin
        cls.terminal   = i_in_word.terminal;
        cls.char_code  = i_in_word.char_code;
        cls.cell_index = i_in_word.cell_index;
        if (int'(i_in_word.terminal) >= TERMINALS) begin
            cls.op = OP_BAD_TERM;
        end else begin
            case (i_in_word.mode)
                MODE_PUT: begin
                    case (i_in_word.char_code)
                        CH_NEWLINE:   cls.op = OP_NEWLINE;
                        CH_TAB:       cls.op = OP_TAB;
                        CH_BLANK:     cls.op = OP_SPACE;
                        CH_BACKSPACE: cls.op = OP_BACKSPACE;
                        default:      cls.op = OP_PUT_CHAR;
                    endcase
                end
                MODE_CLEAR: cls.op = OP_CLEAR;
                MODE_READ:  cls.op = OP_READ;
                default:    cls.op = OP_NONE;
            endcase
        end
    end

    assign o_full      = (r_count == (QA_W+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rp];
    assign do_push     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_queue[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_take) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !i_cmd_take) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && i_cmd_take) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tcow_back.sv
// Back part: cursor sequencer, character store with line valid bits, result register.
module tcow_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tcow_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  logic [tcow_pkg::CHAR_W-1:0] i_attr,
    output logic           o_empty,
    input  logic           i_pop,
    output tcow_pkg::t_out_word o_out_word
);
    import tcow_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_mem_q;

    logic [SLOTS-1:0]  r_valid;
    logic [ROW_W-1:0]  r_top     [TERMINALS];
    logic [ROW_W-1:0]  r_row_arr [TERMINALS];
    logic [COL_W-1:0]  r_col_arr [TERMINALS];

    t_cmd              r_cmd;
    logic [ROW_W-1:0]  r_wrow;
    logic [COL_W-1:0]  r_wcol;
    logic [NCOL_W-1:0] r_ncol;
    logic [SLOT_W-1:0] r_slot;
    logic [COL_W-1:0]  r_sweep;
    logic [IDX_W-1:0]  r_q;
    logic [IDX_W-1:0]  r_rrow;
    logic [COL_W-1:0]  r_rcol;
    logic              r_inrange;
    logic              r_moved;
    logic [CHAR_W-1:0] r_rd_char;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [TIDX_W-1:0] t_idx;
    logic [TIDX_W-1:0] h_idx;
    logic [ROW_W-1:0]  h_row;
    logic [COL_W-1:0]  h_col;
    logic [SLOT_W-1:0] cur_slot;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              out_load;
    logic [COL_W+TAB_S:0]   tab_prod;
    logic [NCOL_W-1:0]      tab_base;
    logic [NCOL_W-1:0]      tab_rem;
    logic [2*IDX_W:0]       rd_prod;
    logic [IDX_W-1:0]       rd_base;
    logic [IDX_W-1:0]       rd_rem;

    assign t_idx    = TIDX_W'(r_cmd.terminal);
    assign h_idx    = TIDX_W'(i_cmd.terminal);
    assign cur_slot = slot_of(t_idx, phys_row(r_wrow, r_top[t_idx]));
    assign tab_prod = (COL_W+TAB_S+1)'(r_wcol) * (COL_W+TAB_S+1)'(TAB_M);
    assign tab_base = NCOL_W'(r_q * TAB_STOP);
    assign tab_rem  = NCOL_W'(r_wcol) - tab_base;
    assign rd_prod  = (2*IDX_W+1)'(r_cmd.cell_index) * (2*IDX_W+1)'(IDX_M);
    assign rd_base  = IDX_W'(r_q * COLS);
    assign rd_rem   = r_cmd.cell_index - rd_base;

    // Cursor of the head command's terminal, with the backspace step or the clear to home applied.
    always_comb begin
        h_row = r_row_arr[h_idx];
        h_col = r_col_arr[h_idx];
        if (i_cmd.op == OP_BACKSPACE) begin
            if (h_col != '0) begin
                h_col = h_col - 1'b1;
            end else if (h_row != '0) begin
                h_row = h_row - 1'b1;
                h_col = COL_W'(COLS - 1);
            end
        end else if (i_cmd.op == OP_CLEAR) begin
            h_row = '0;
            h_col = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_CLEAR:                 n_state = BK_CLEAR;
                        OP_SPACE, OP_NEWLINE:     n_state = BK_WRAP;
                        OP_TAB:                   n_state = BK_TAB_Q;
                        OP_PUT_CHAR, OP_BACKSPACE: n_state = BK_SLOT;
                        OP_READ:                  n_state = BK_RD_Q;
                        default:                  n_state = BK_DONE;
                    endcase
                end
            end
            BK_SLOT: begin
                if (r_valid[cur_slot]) begin
                    n_state = BK_WRITE;
                end else if (r_cmd.op == OP_BACKSPACE) begin
                    n_state = BK_DONE;
                end else begin
                    n_state = BK_SWEEP;
                end
            end
            BK_SWEEP: begin
                if (r_sweep == COL_W'(COLS - 1)) begin
                    n_state = BK_WRITE;
                end
            end
            BK_WRITE: begin
                n_state = (r_cmd.op == OP_BACKSPACE) ? BK_DONE : BK_WRAP;
            end
            BK_TAB_Q:   n_state = BK_TAB_ADV;
            BK_TAB_ADV: n_state = BK_WRAP;
            BK_WRAP: begin
                if (int'(r_ncol) < COLS) begin
                    n_state = BK_DONE;
                end
            end
            BK_CLEAR:   n_state = BK_DONE;
            BK_RD_Q:    n_state = BK_RD_ADJ;
            BK_RD_ADJ:  n_state = BK_RD_SLOT;
            BK_RD_SLOT: n_state = BK_RD_MEM;
            BK_RD_MEM:  n_state = BK_RD_DATA;
            BK_RD_DATA: n_state = BK_DONE;
            BK_DONE: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default:    n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = CH_BLANK;
        mem_addr   = ADDR_W'(r_slot * COLS) + ADDR_W'(r_wcol);
        case (r_state)
            BK_IDLE: o_cmd_take = i_cmd_valid;
            BK_SWEEP: begin
                mem_we   = 1'b1;
                mem_addr = ADDR_W'(r_slot * COLS) + ADDR_W'(r_sweep);
            end
            BK_WRITE: begin
                mem_we = 1'b1;
                if (r_cmd.op != OP_BACKSPACE) begin
                    mem_wdata = r_cmd.char_code;
                end
            end
            BK_RD_MEM: mem_addr = ADDR_W'(r_slot * COLS) + ADDR_W'(r_rcol);
            BK_DONE:   out_load = !r_out_valid || i_pop;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < TERMINALS; i++) begin
                r_top[i]     <= '0;
                r_row_arr[i] <= '0;
                r_col_arr[i] <= '0;
            end
        end else begin
            case (r_state)
                BK_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd     <= i_cmd;
                        r_moved   <= 1'b0;
                        r_rd_char <= '0;
                        r_wrow    <= h_row;
                        r_wcol    <= h_col;
                        if (i_cmd.op == OP_NEWLINE) begin
                            r_ncol <= NCOL_W'(COLS);
                        end else begin
                            r_ncol <= NCOL_W'(h_col) + 1'b1;
                        end
                    end
                end
                BK_SLOT: begin
                    r_slot  <= cur_slot;
                    r_sweep <= '0;
                end
                BK_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == COL_W'(COLS - 1)) begin
                        r_valid[r_slot] <= 1'b1;
                    end
                end
                BK_WRITE: r_ncol <= NCOL_W'(r_wcol) + 1'b1;
                BK_TAB_Q: r_q <= IDX_W'(tab_prod >> TAB_S);
                BK_TAB_ADV: begin
                    if (int'(tab_rem) >= TAB_STOP) begin
                        r_ncol <= tab_base + NCOL_W'(2 * TAB_STOP);
                    end else begin
                        r_ncol <= tab_base + NCOL_W'(TAB_STOP);
                    end
                end
                BK_WRAP: begin
                    if (int'(r_ncol) >= COLS) begin
                        r_ncol <= r_ncol - NCOL_W'(COLS);
                        if (r_wrow == ROW_W'(ROWS - 1)) begin
                            // The top line becomes the blank bottom line.
                            r_valid[slot_of(t_idx, r_top[t_idx])] <= 1'b0;
                            if (r_top[t_idx] == ROW_W'(ROWS - 1)) begin
                                r_top[t_idx] <= '0;
                            end else begin
                                r_top[t_idx] <= r_top[t_idx] + 1'b1;
                            end
                            r_moved <= 1'b1;
                        end else begin
                            r_wrow <= r_wrow + 1'b1;
                        end
                    end else begin
                        r_wcol <= COL_W'(r_ncol);
                    end
                end
                BK_CLEAR: begin
                    for (int r = 0; r < ROWS; r++) begin
                        r_valid[slot_of(t_idx, ROW_W'(r))] <= 1'b0;
                    end
                end
                BK_RD_Q: begin
                    r_q       <= IDX_W'(rd_prod >> IDX_S);
                    r_inrange <= (int'(r_cmd.cell_index) < CELLS);
                end
                BK_RD_ADJ: begin
                    if (int'(rd_rem) >= COLS) begin
                        r_rrow <= r_q + 1'b1;
                        r_rcol <= COL_W'(rd_rem - IDX_W'(COLS));
                    end else begin
                        r_rrow <= r_q;
                        r_rcol <= COL_W'(rd_rem);
                    end
                end
                BK_RD_SLOT: begin
                    if (r_inrange) begin
                        r_slot <= slot_of(t_idx, phys_row(ROW_W'(r_rrow), r_top[t_idx]));
                    end else begin
                        r_slot <= '0;
                    end
                end
                BK_RD_DATA: begin
                    if (!r_inrange) begin
                        r_rd_char <= '0;
                    end else if (r_valid[r_slot]) begin
                        r_rd_char <= r_mem_q;
                    end else begin
                        r_rd_char <= CH_BLANK;
                    end
                end
                BK_DONE: begin
                    if (out_load) begin
                        r_row_arr[t_idx] <= r_wrow;
                        r_col_arr[t_idx] <= r_wcol;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.cell_char      <= r_rd_char;
            r_out.cell_attribute <= (r_cmd.op == OP_READ) ? i_attr : '0;
            r_out.scrolled       <= r_moved;
            if (r_cmd.op == OP_BAD_TERM) begin
                r_out.cursor_position <= '0;
            end else begin
                r_out.cursor_position <= IDX_W'(r_wrow * COLS) + IDX_W'(r_wcol);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

endmodule

>>> rtl/text_console_output_writer.sv
// Top level of the text console output writer: register port, front, back and checks.
//
//   channel   direction  handshake               word
//   input     in         push / full             i_in_word (t_in_word)
//   result    out        pop / empty             o_out_word (t_out_word)
//   config    in         psel, penable, pwrite   pwdata, paddr; prdata read back
//
// In the back sequencer a put passes slot, write and wrap; a first write into a blank
// line first fills it with spaces, one cell per cycle. Space and newline go to wrap,
// tab via quotient and advance; each wrap or scroll repeats wrap. Clear passes its
// clear state, a cell read its quotient, adjust, slot, memory and data states.
// Reset clears the line valid bits at once, so no clearing pass follows reset.
// A four word command queue lets input words be taken while the back part or the
// result register is stalled.
module text_console_output_writer (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  tcow_pkg::t_in_word i_in_word,
    output logic empty,
    input  logic pop,
    output tcow_pkg::t_out_word o_out_word,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [tcow_pkg::APB_AW-1:0] paddr,
    input  logic [tcow_pkg::APB_DW-1:0] pwdata,
    output logic [tcow_pkg::APB_DW-1:0] prdata,
    output logic pready
);
    import tcow_pkg::*;

    logic [CHAR_W-1:0] r_attr;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              cmd_take;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_ATTR);
    assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? APB_DW'(r_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (cfg_write) begin
            r_attr <= pwdata[CHAR_W-1:0];
        end
    end

    tcow_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    tcow_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_attr      (r_attr),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_word  (o_out_word)
    );

    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("Back part took a command from an empty queue.");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_out_word.cursor_position) < CELLS))
        else $error("Reported cursor lies outside the grid.");

    a_scroll_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_word.scrolled) |->
            (o_out_word.cell_char == '0 && o_out_word.cell_attribute == '0))
        else $error("A scrolling word also carries read data.");

endmodule

>>> bench/tcow_checker.sv
// Checker of the text console output writer: mirrors the terminals and compares each result word.
module tcow_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    input  logic                         full,
    input  tcow_pkg::t_in_word           i_in_word,
    input  logic                         empty,
    input  logic                         pop,
    input  tcow_pkg::t_out_word          o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [tcow_pkg::APB_AW-1:0]  paddr,
    input  logic [tcow_pkg::APB_DW-1:0]  pwdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcow_pkg::*;

    localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'(4 * REG_TEXT_ATTR);

    logic [CHAR_W-1:0] shadow_cells [TERMINALS*CELLS];
    logic [IDX_W-1:0]  shadow_cursor [TERMINALS];
    logic [CHAR_W-1:0] shadow_attr;
    t_out_word         awaited_results [$];
    t_out_word         oldest;
    int                fail_count;

    function automatic void scroll_grid(input int base);
        for (int c = 0; c < CELLS - COLS; c++) begin
            shadow_cells[base + c] = shadow_cells[base + c + COLS];
        end
        for (int c = CELLS - COLS; c < CELLS; c++) begin
            shadow_cells[base + c] = CH_BLANK;
        end
    endfunction

    function automatic logic advance_cursor(input int t, input int step);
        int   pos;
        logic moved;
        pos = int'(shadow_cursor[t]) + step;
        moved = 1'b0;
        while (pos >= CELLS) begin
            pos -= COLS;
            scroll_grid(t * CELLS);
            moved = 1'b1;
        end
        shadow_cursor[t] = IDX_W'(pos);
        return moved;
    endfunction

    function automatic t_out_word console_step(input t_in_word w);
        t_out_word r;
        int        t;
        int        base;
        int        pos;
        r = '0;
        t = int'(w.terminal);
        if (t >= TERMINALS) begin
            return r;
        end
        base = t * CELLS;
        pos = int'(shadow_cursor[t]);
        if (pos >= CELLS) begin
            pos = 0;
        end
        shadow_cursor[t] = IDX_W'(pos);
        case (w.mode)
            MODE_PUT: begin
                case (w.char_code)
                    CH_NEWLINE:   r.scrolled = advance_cursor(t, COLS - pos % COLS);
                    CH_TAB:       r.scrolled = advance_cursor(t, TAB_STOP - pos % TAB_STOP);
                    CH_BLANK:     r.scrolled = advance_cursor(t, 1);
                    CH_BACKSPACE: begin
                        if (pos > 0) begin
                            pos--;
                        end
                        shadow_cursor[t] = IDX_W'(pos);
                        shadow_cells[base + pos] = CH_BLANK;
                    end
                    default: begin
                        shadow_cells[base + pos] = w.char_code;
                        r.scrolled = advance_cursor(t, 1);
                    end
                endcase
            end
            MODE_CLEAR: begin
                for (int c = 0; c < CELLS; c++) begin
                    shadow_cells[base + c] = CH_BLANK;
                end
                shadow_cursor[t] = '0;
            end
            MODE_READ: begin
                r.cell_attribute = shadow_attr;
                if (w.cell_index < CELLS) begin
                    r.cell_char = shadow_cells[base + int'(w.cell_index)];
                end
            end
            default: begin
            end
        endcase
        r.cursor_position = shadow_cursor[t];
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    initial begin
        for (int c = 0; c < TERMINALS * CELLS; c++) begin
            shadow_cells[c] = CH_BLANK;
        end
        for (int t = 0; t < TERMINALS; t++) begin
            shadow_cursor[t] = '0;
        end
        shadow_attr = ATTR_RESET;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
                shadow_attr = pwdata[CHAR_W-1:0];
            end
            if (pop && !empty) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing expected: %p", o_out_word);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("cell_char", oldest.cell_char, o_out_word.cell_char);
                    check_field("cell_attribute", oldest.cell_attribute,
                                o_out_word.cell_attribute);
                    check_field("cursor_position", oldest.cursor_position,
                                o_out_word.cursor_position);
                    check_field("scrolled", oldest.scrolled, o_out_word.scrolled);
                end
            end
            if (push && !full) begin
                awaited_results.push_back(console_step(i_in_word));
            end
            o_pending <= awaited_results.size();
            o_fail_count <= fail_count;
        end
    end

endmodule

>>> bench/tb.sv
// Testbench top of the text console output writer: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcow_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'(4 * REG_TEXT_ATTR);
    localparam int RANDOM_ITEMS   = 1880;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_word in_word = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_word out_word;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    int fail_count;
    int pending_count;
    int tx_idle_pct = 19;
    int rx_idle_pct = 61;
    logic hold_req = 1'b0;
    logic hold_served = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    text_console_output_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tcow_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_word    (in_word),
        .empty        (empty),
        .pop          (pop),
        .o_out_word   (out_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            pop <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word make_word(input logic [MODE_W-1:0] mode,
                                           input logic [TERM_W-1:0] t,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [IDX_W-1:0] idx);
        t_in_word w;
        w.mode = mode;
        w.terminal = t;
        w.char_code = ch;
        w.cell_index = idx;
        return w;
    endfunction

    function automatic t_in_word random_console_word(input logic [TERM_W-1:0] t);
        t_in_word w;
        int pick;
        w = make_word(MODE_PUT, t, CHAR_W'($urandom_range(255)),
                      IDX_W'($urandom_range(2047)));
        pick = $urandom_range(999);
        if (pick < 450) begin
            w.char_code = CHAR_W'($urandom_range(8'h21, 8'h7E));
        end else if (pick < 580) begin
            w.char_code = CH_NEWLINE;
        end else if (pick < 650) begin
            w.char_code = CH_TAB;
        end else if (pick < 720) begin
            w.char_code = CH_BLANK;
        end else if (pick < 780) begin
            w.char_code = CH_BACKSPACE;
        end else if (pick < 900) begin
            w.mode = MODE_READ;
            if ($urandom_range(99) < 85) begin
                w.cell_index = IDX_W'($urandom_range(CELLS - 1));
            end else begin
                w.cell_index = IDX_W'($urandom_range(CELLS, 2047));
            end
        end else if (pick < 903) begin
            w.mode = MODE_CLEAR;
        end else if (pick < 906) begin
            w.mode = MODE_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [CHAR_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ATTR_ADDR;
        pwdata <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_random_phase(input int items, input int phase);
        int sent;
        int burst;
        logic long_line;
        logic [TERM_W-1:0] t;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) < 7) begin
                t = TERM_W'($urandom_range(2));
            end else begin
                t = TERM_W'($urandom_range(TERMINALS - 1));
            end
            long_line = ($urandom_range(9) == 0);
            burst = long_line ? $urandom_range(60, 100) : $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < items; k++) begin
                if (long_line) begin
                    send_word(make_word(MODE_PUT, t, CHAR_W'($urandom_range(8'h21, 8'h7E)),
                                        IDX_W'($urandom_range(2047))));
                end else begin
                    send_word(random_console_word(t));
                end
                sent++;
                if (phase == 1 && sent == items / 2) begin
                    wait_drained();
                end
                if (phase == 2 && sent == 60) begin
                    hold_req <= 1'b1;
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default attribute first, then both extremes of the register.
        send_word(make_word(MODE_PUT, 3'd0, 8'h48, 11'd0));
        send_word(make_word(MODE_PUT, 3'd0, 8'h00, 11'd2047));
        send_word(make_word(MODE_PUT, 3'd0, 8'hFF, 11'd0));
        send_word(make_word(MODE_PUT, 3'd0, CH_BLANK, 11'd0));
        send_word(make_word(MODE_PUT, 3'd0, CH_TAB, 11'd0));
        send_word(make_word(MODE_PUT, 3'd0, CH_NEWLINE, 11'd0));
        send_word(make_word(MODE_PUT, 3'd0, CH_BACKSPACE, 11'd0));
        send_word(make_word(MODE_READ, 3'd0, 8'h00, 11'd0));
        send_word(make_word(MODE_READ, 3'd0, 8'h00, 11'd2));
        send_word(make_word(MODE_READ, 3'd0, 8'hFF, 11'(CELLS - 1)));
        send_word(make_word(MODE_READ, 3'd0, 8'h00, 11'(CELLS)));
        send_word(make_word(MODE_READ, 3'd0, 8'h00, 11'd2047));
        send_word(make_word(MODE_UNUSED, 3'd0, 8'hFF, 11'd2047));
        send_word(make_word(MODE_CLEAR, 3'd0, 8'h41, 11'd5));
        send_word(make_word(MODE_PUT, 3'd0, CH_BACKSPACE, 11'd0));
        send_word(make_word(MODE_READ, 3'd0, 8'h00, 11'd0));
        send_word(make_word(MODE_PUT, 3'd7, 8'h7F, 11'd0));
        write_attribute(8'h00);
        send_word(make_word(MODE_READ, 3'd7, 8'h00, 11'd0));
        write_attribute(8'hFF);
        send_word(make_word(MODE_READ, 3'd7, 8'h00, 11'd0));
        send_word(make_word(MODE_READ, 3'd7, 8'h00, 11'd2047));

        for (int phase = 0; phase < 3; phase++) begin
            write_attribute(CHAR_W'($urandom_range(255)));
            tx_idle_pct <= (phase == 0) ? 19 : (phase == 1) ? 61 : 0;
            rx_idle_pct <= (phase == 0) ? 61 : (phase == 1) ? 19 : 0;
            run_random_phase(RANDOM_ITEMS / 3, phase);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> text_console_output_writer.f
rtl/tcow_pkg.sv
rtl/tcow_front.sv
rtl/tcow_back.sv
rtl/text_console_output_writer.sv
bench/tcow_checker.sv
bench/tb.sv
